[sv/spirv_vendor_decoration_stripper_core_macros.svh]
// assertion macros shared by the vendor decoration stripper modules
// expects a clock named clk and an active-high reset named rst in scope
`ifndef SPIRV_VENDOR_DECORATION_STRIPPER_CORE_MACROS_SVH
`define SPIRV_VENDOR_DECORATION_STRIPPER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SVDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SVDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/svds_pkg.sv]
// shared types, opcodes and extension name table for the decoration stripper
// no dependencies
`timescale 1ns / 1ps

package svds_pkg;

  localparam int HOLD_DEPTH_DEF = 16;

  localparam logic [15:0] OP_EXTENSION      = 16'd10;
  localparam logic [15:0] OP_DEC_STR        = 16'd5632;
  localparam logic [15:0] OP_MEMBER_DEC_STR = 16'd5633;

  localparam int HEADER_WORDS = 5;
  // string words that take part in the name compare
  localparam int NAME_WORDS = 8;
  // extension header word plus the name words
  localparam int NAME_MIN_WORDS = NAME_WORDS + 1;

  // little-endian name words, terminator byte included in the last one
  localparam logic [31:0] NAME_WORD [0:NAME_WORDS-1] = '{
    32'h5F565053, 32'h474F4F47, 32'h685F454C, 32'h5F6C736C,
    32'h636E7566, 32'h6E6F6974, 32'h74696C61, 32'h00003179
  };
  localparam logic [31:0] NAME_MASK [0:NAME_WORDS-1] = '{
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00FFFFFF
  };

  typedef struct packed {
    logic emit;
    logic ovf;
    logic bare;
    logic last_end;
    logic hdr_inc;
    logic wl_load;
    logic wl_dec;
    logic hold_start;
    logic hold;
    logic drop;
    logic flush_start;
    logic clear;
    logic flushing;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic wc_zero;
    logic wc_one;
    logic wc_big;
    logic cand;
    logic ext;
    logic wl_one;
    logic hdr_done;
    logic drop_now;
    logic flush_done;
  } sts_t;

  function automatic logic name_word_ok(input logic [2:0] idx, input logic [31:0] w);
    name_word_ok = ((w ^ NAME_WORD[idx]) & NAME_MASK[idx]) == 32'd0;
  endfunction

endpackage

[sv/svds_datapath.sv]
// datapath: word decode, counters, hold memory, name compare, flush engine, output register
// depends on svds_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "spirv_vendor_decoration_stripper_core_macros.svh"

module svds_datapath import svds_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] word,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word_out,
  output logic        word_valid,
  output logic        stream_end,
  output logic        hold_overflow
);

  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int AW    = $clog2(HOLD_DEPTH);

  logic [15:0]      wc;
  logic [15:0]      op;
  logic [2:0]       header_count;
  logic [15:0]      words_left;
  logic [CNT_W-1:0] held_count;
  logic             candidate_kind;
  logic             name_match;
  logic [CNT_W-1:0] rd_ptr;
  logic             q_valid;
  logic [31:0]      q_word;
  logic             flush_end;
  logic [31:0]      mem [0:HOLD_DEPTH-1];

  logic [CNT_W-1:0] str_idx;
  logic             word_ok;
  logic             nm_next;
  logic [CNT_W:0]   held_after;
  logic             out_free;
  logic             q_load;
  logic             rd_en;
  logic             flush_done;
  logic             q_is_last;
  logic             out_load;
  logic [AW-1:0]    wr_addr;

  assign wc = word[31:16];
  assign op = word[15:0];

  // string word index of the incoming word inside the held extension
  assign str_idx    = held_count - CNT_W'(1);
  assign word_ok    = (str_idx >= CNT_W'(NAME_WORDS)) || name_word_ok(str_idx[2:0], word);
  assign nm_next    = name_match && word_ok;
  assign held_after = {1'b0, held_count} + (CNT_W + 1)'(1);

  assign out_free   = !out_valid || !out_stall;
  assign q_load     = cmd.flushing && q_valid && out_free;
  assign rd_en      = cmd.flushing && (rd_ptr < held_count) && (!q_valid || q_load);
  assign q_is_last  = rd_ptr == held_count;
  assign flush_done = q_load && q_is_last;
  assign out_load   = cmd.emit || cmd.bare || q_load;
  assign wr_addr    = cmd.hold_start ? '0 : held_count[AW-1:0];

  always_comb begin
    sts.out_free   = out_free;
    sts.wc_zero    = wc == 16'd0;
    sts.wc_one     = wc == 16'd1;
    sts.wc_big     = wc > 16'(HOLD_DEPTH);
    sts.ext        = op == OP_EXTENSION;
    sts.cand       = (op == OP_EXTENSION) || (op == OP_DEC_STR) || (op == OP_MEMBER_DEC_STR);
    sts.wl_one     = words_left == 16'd1;
    sts.hdr_done   = header_count == 3'(HEADER_WORDS - 1);
    sts.drop_now   = !candidate_kind ||
                     (nm_next && (held_after >= (CNT_W + 1)'(NAME_MIN_WORDS)));
    sts.flush_done = flush_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count   <= '0;
      words_left     <= '0;
      held_count     <= '0;
      candidate_kind <= 1'b0;
      name_match     <= 1'b0;
      rd_ptr         <= '0;
      q_valid        <= 1'b0;
      flush_end      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.hdr_inc) begin
        header_count <= header_count + 3'd1;
      end
      if (cmd.wl_load) begin
        words_left <= wc - 16'd1;
      end else if (cmd.wl_dec) begin
        words_left <= words_left - 16'd1;
      end
      if (cmd.hold_start) begin
        candidate_kind <= sts.ext;
        name_match     <= 1'b1;
        held_count     <= CNT_W'(1);
      end else if (cmd.hold) begin
        held_count <= held_after[CNT_W-1:0];
        if (candidate_kind) begin
          name_match <= nm_next;
        end
      end
      if (cmd.drop || flush_done) begin
        held_count <= '0;
      end
      if (cmd.clear) begin
        header_count   <= '0;
        words_left     <= '0;
        candidate_kind <= 1'b0;
        name_match     <= 1'b0;
      end
      if (cmd.flush_start) begin
        rd_ptr    <= '0;
        q_valid   <= 1'b0;
        flush_end <= cmd.last_end;
      end else if (rd_en) begin
        rd_ptr  <= rd_ptr + CNT_W'(1);
        q_valid <= 1'b1;
      end else if (q_load) begin
        q_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_start || cmd.hold) begin
      mem[wr_addr] <= word;
    end
    if (rd_en) begin
      q_word <= mem[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_load) begin
      word_out      <= q_word;
      word_valid    <= 1'b1;
      stream_end    <= flush_end && q_is_last;
      hold_overflow <= 1'b0;
    end else if (cmd.emit) begin
      word_out      <= word;
      word_valid    <= 1'b1;
      stream_end    <= cmd.last_end;
      hold_overflow <= cmd.ovf;
    end else if (cmd.bare) begin
      word_out      <= 32'd0;
      word_valid    <= 1'b0;
      stream_end    <= 1'b1;
      hold_overflow <= 1'b0;
    end
  end

  `SVDS_ASSERT_NOW(a_held_bound, 1'b1, held_count <= CNT_W'(HOLD_DEPTH), "held count beyond store depth")
  `SVDS_ASSERT_NOW(a_flush_read_first, q_load, rd_ptr != '0, "flush output without a prior read")

endmodule

[sv/svds_ctrl.sv]
// controller: stream phase state machine issuing datapath commands
// depends on svds_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "spirv_vendor_decoration_stripper_core_macros.svh"

module svds_ctrl import svds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic last,
  output logic in_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    PH_HDR, PH_INST, PH_PASS, PH_OVF, PH_HOLD, PH_BYP, PH_FLUSH
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  logic   ret_hdr;
  logic   ret_hdr_next;
  logic   accept;

  assign in_stall = (phase == PH_FLUSH) || !sts.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic finish;
    logic drop_sel;
    logic flush_req;
    finish       = 1'b0;
    drop_sel     = 1'b0;
    flush_req    = 1'b0;
    cmd          = '0;
    phase_next   = phase;
    ret_hdr_next = ret_hdr;
    cmd.flushing = phase == PH_FLUSH;

    if (phase == PH_FLUSH && sts.flush_done) begin
      phase_next = ret_hdr ? PH_HDR : PH_INST;
    end

    if (accept) begin
      case (phase)
        PH_HDR: begin
          cmd.emit    = 1'b1;
          cmd.hdr_inc = 1'b1;
          if (sts.hdr_done) begin
            phase_next = PH_INST;
          end
        end
        PH_INST: begin
          if (sts.wc_zero) begin
            cmd.emit   = 1'b1;
            phase_next = PH_BYP;
          end else if (sts.cand && sts.wc_big) begin
            cmd.emit    = 1'b1;
            cmd.ovf     = 1'b1;
            cmd.wl_load = 1'b1;
            phase_next  = PH_OVF;
          end else if (sts.cand) begin
            cmd.hold_start = 1'b1;
            cmd.wl_load    = 1'b1;
            phase_next     = PH_HOLD;
            if (sts.wc_one) begin
              finish   = 1'b1;
              drop_sel = !sts.ext;
            end else if (last) begin
              flush_req = 1'b1;
            end
          end else begin
            cmd.emit    = 1'b1;
            cmd.wl_load = 1'b1;
            if (!sts.wc_one) begin
              phase_next = PH_PASS;
            end
          end
        end
        PH_PASS, PH_OVF: begin
          cmd.emit   = 1'b1;
          cmd.ovf    = phase == PH_OVF;
          cmd.wl_dec = 1'b1;
          if (sts.wl_one) begin
            phase_next = PH_INST;
          end
        end
        PH_HOLD: begin
          cmd.hold   = 1'b1;
          cmd.wl_dec = 1'b1;
          if (sts.wl_one) begin
            finish   = 1'b1;
            drop_sel = sts.drop_now;
          end else if (last) begin
            flush_req = 1'b1;
          end
        end
        default: begin
          cmd.emit = 1'b1;
        end
      endcase

      if (finish) begin
        if (drop_sel) begin
          cmd.drop   = 1'b1;
          phase_next = PH_INST;
        end else begin
          flush_req = 1'b1;
        end
      end
      if (flush_req) begin
        cmd.flush_start = 1'b1;
        phase_next      = PH_FLUSH;
        ret_hdr_next    = last;
      end
      if (last) begin
        cmd.clear    = 1'b1;
        cmd.last_end = 1'b1;
        cmd.bare     = !cmd.emit && !flush_req;
        if (!flush_req) begin
          phase_next = PH_HDR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR;
      ret_hdr <= 1'b0;
    end else begin
      phase   <= phase_next;
      ret_hdr <= ret_hdr_next;
    end
  end

  `SVDS_ASSERT_NEXT(a_bare_restarts, cmd.bare, phase == PH_HDR, "end marker did not restart the header phase")
  `SVDS_ASSERT_NOW(a_done_in_flush, sts.flush_done, phase == PH_FLUSH, "flush done outside flush phase")
  `SVDS_ASSERT_NEXT(a_flush_entered, cmd.flush_start, phase == PH_FLUSH, "flush start without flush phase")

endmodule

[sv/spirv_vendor_decoration_stripper_core.sv]
// Vendor decoration stripper for a SPIR-V word stream.
//
// Input channel: word, last with in_valid / in_stall. Output channel: word_out,
// word_valid, stream_end, hold_overflow with out_valid / out_stall. An item moves
// when valid is high and stall is low.
// The five header words and ordinary instructions pass through the output register
// one word per cycle unless out_stall holds it. Decoration-string instructions and
// extension instructions are held in a HOLD_DEPTH-word memory until complete,
// then dropped or released. A release reads the memory through a read register
// one word per cycle unless out_stall holds the output; in_stall is high
// throughout. The memory read port sets that rate.
// A candidate longer than HOLD_DEPTH words passes through with hold_overflow set.
// A word count of zero sends the rest of the module through unchanged.
// A module whose final word is dropped ends with a bare item: word_valid low,
// stream_end high. After the final word, and any release it starts, the decode state returns to its reset value.
// Reset is synchronous; the hold memory is not cleared and needs no clearing pass.
// When out_stall is high with out_valid set, the output register holds and in_stall rises at once.
// depends on svds_pkg, svds_ctrl and svds_datapath
`timescale 1ns / 1ps

module spirv_vendor_decoration_stripper_core import svds_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word_out,
  output logic        word_valid,
  output logic        stream_end,
  output logic        hold_overflow
);

  cmd_t cmd;
  sts_t sts;

  svds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  svds_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .word          (word),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .word_out      (word_out),
    .word_valid    (word_valid),
    .stream_end    (stream_end),
    .hold_overflow (hold_overflow)
  );

endmodule

[verif/spirv_vendor_decoration_stripper_core_tb.sv]
// testbench for spirv_vendor_decoration_stripper_core: random module streams checked
// against a word-level stripping predictor, with random idling on both channels
// depends on svds_pkg and spirv_vendor_decoration_stripper_core
`timescale 1ns / 1ps

module spirv_vendor_decoration_stripper_core_tb;
  import svds_pkg::*;

  localparam int HOLD = HOLD_DEPTH_DEF;
  localparam int NAME_BYTES = 4 * NAME_WORDS - 1;
  localparam int BODY_CAP = 24;
  localparam int RANDOM_ITEMS = 195;
  localparam int IDLE_LIMIT = 2000;
  localparam int SQUEEZE_AT = 110;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [31:0] w;
    logic        l;
  } src_item_t;

  typedef struct packed {
    logic [31:0] w;
    logic        wv;
    logic        se;
    logic        ovf;
  } kept_t;

  typedef enum logic [2:0] {ST_HDR, ST_INST, ST_PASS, ST_OVF, ST_HOLD, ST_BYP} strip_st_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] word = 32'h0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] word_out;
  logic        word_valid;
  logic        stream_end;
  logic        hold_overflow;

  spirv_vendor_decoration_stripper_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .word         (word),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .word_out     (word_out),
    .word_valid   (word_valid),
    .stream_end   (stream_end),
    .hold_overflow(hold_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  src_item_t   word_q[$];
  logic [31:0] module_q[$];
  kept_t       kept_q[$];
  int          n_items = 0;
  int          n_words_in = 0;
  int          n_err = 0;
  int          idle_cycles = 0;

  function automatic void add_kept(input kept_t k);
    kept_q.insert(kept_q.size(), k);
  endfunction

  function automatic void add_mod(input logic [31:0] w);
    module_q.insert(module_q.size(), w);
  endfunction

  // ---------------------------------------------------------------- predictor state
  strip_st_t   st;
  int          hdr_cnt;
  logic [15:0] words_left;
  logic [31:0] held_mem [HOLD];
  int          held_n;
  logic        is_ext;
  logic        name_ok;

  function automatic void clear_strip();
    st = ST_HDR;
    hdr_cnt = 0;
    words_left = 16'd0;
    held_n = 0;
    is_ext = 1'b0;
    name_ok = 1'b0;
  endfunction

  function automatic void keep_word(input logic [31:0] w, input logic ovf);
    add_kept({w, 1'b1, 1'b0, ovf});
  endfunction

  function automatic void hold_in(input logic [31:0] w);
    int p;
    if (held_n >= HOLD) return;
    // string bytes start after the extension header word
    if (is_ext && held_n >= 1) begin
      for (int k = 0; k < 4; k++) begin
        p = (held_n - 1) * 4 + k;
        if (p < NAME_BYTES) begin
          if (w[8*k +: 8] != NAME_WORD[p / 4][8*(p % 4) +: 8]) name_ok = 1'b0;
        end
      end
    end
    held_mem[held_n] = w;
    held_n++;
  endfunction

  function automatic void release_held();
    for (int i = 0; i < held_n; i++) keep_word(held_mem[i], 1'b0);
    held_n = 0;
  endfunction

  function automatic void close_candidate();
    if (!is_ext || (name_ok && held_n >= NAME_MIN_WORDS)) held_n = 0;
    else release_held();
    st = ST_INST;
  endfunction

  function automatic void strip_word(input logic [31:0] w, input logic l);
    int          n_before;
    logic [15:0] wc;
    logic [15:0] op;
    logic        cand;
    n_before = kept_q.size();
    wc = w[31:16];
    op = w[15:0];
    cand = (op == OP_EXTENSION) || (op == OP_DEC_STR) || (op == OP_MEMBER_DEC_STR);
    case (st)
      ST_HDR: begin
        keep_word(w, 1'b0);
        hdr_cnt++;
        if (hdr_cnt >= HEADER_WORDS) st = ST_INST;
      end
      ST_INST: begin
        if (wc == 16'd0) begin
          keep_word(w, 1'b0);
          st = ST_BYP;
        end else if (cand && wc > HOLD) begin
          keep_word(w, 1'b1);
          words_left = wc - 16'd1;
          st = ST_OVF;
        end else if (cand) begin
          is_ext = (op == OP_EXTENSION);
          name_ok = 1'b1;
          held_n = 0;
          hold_in(w);
          words_left = wc - 16'd1;
          st = ST_HOLD;
          if (words_left == 16'd0) close_candidate();
          else if (l) release_held();
        end else begin
          keep_word(w, 1'b0);
          words_left = wc - 16'd1;
          if (words_left != 16'd0) st = ST_PASS;
        end
      end
      ST_PASS, ST_OVF: begin
        keep_word(w, st == ST_OVF);
        words_left = words_left - 16'd1;
        if (words_left == 16'd0) st = ST_INST;
      end
      ST_HOLD: begin
        hold_in(w);
        words_left = words_left - 16'd1;
        if (words_left == 16'd0) close_candidate();
        else if (l) release_held();
      end
      default: keep_word(w, 1'b0);
    endcase
    if (l) begin
      // a module ending on a dropped word still closes with a bare end marker
      if (kept_q.size() == n_before) add_kept({32'h0, 1'b0, 1'b0, 1'b0});
      kept_q[kept_q.size() - 1].se = 1'b1;
      clear_strip();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [15:0] plain_op();
    logic [15:0] op;
    do op = 16'($urandom);
    while (op == OP_EXTENSION || op == OP_DEC_STR || op == OP_MEMBER_DEC_STR);
    return op;
  endfunction

  function automatic logic [15:0] cand_op();
    case ($urandom_range(0, 2))
      0: return OP_EXTENSION;
      1: return OP_DEC_STR;
      default: return OP_MEMBER_DEC_STR;
    endcase
  endfunction

  function automatic void put_inst(input logic [15:0] op, input int wc);
    logic [15:0] wc16;
    wc16 = 16'(wc);
    add_mod({wc16, op});
    for (int i = 1; i < wc && i <= BODY_CAP; i++) add_mod($urandom);
  endfunction

  // extension with the vendor name; bad flips one bit inside the compared bytes
  function automatic void put_ext(input int wc, input bit bad);
    int          base;
    int          bw;
    int          bb;
    logic [15:0] wc16;
    logic [31:0] v;
    base = module_q.size();
    wc16 = 16'(wc);
    add_mod({wc16, OP_EXTENSION});
    for (int i = 1; i < wc; i++) begin
      if (i <= NAME_WORDS) begin
        v = NAME_WORD[i - 1];
        if (i == NAME_WORDS) v[31:24] = 8'($urandom);
      end else begin
        v = $urandom;
      end
      add_mod(v);
    end
    if (bad && wc > NAME_WORDS) begin
      bw = $urandom_range(0, NAME_WORDS - 1);
      bb = (bw == NAME_WORDS - 1) ? $urandom_range(0, 23) : $urandom_range(0, 31);
      module_q[base + 1 + bw][bb] = ~module_q[base + 1 + bw][bb];
    end
  endfunction

  function automatic void put_header();
    for (int i = 0; i < HEADER_WORDS; i++) add_mod($urandom);
  endfunction

  // keep = 0 sends the whole module, otherwise it is cut after keep words
  function automatic void close_module(input int keep);
    int        n;
    src_item_t it;
    n = (keep > 0 && keep < module_q.size()) ? keep : module_q.size();
    for (int i = 0; i < n; i++) begin
      it.w = module_q[i];
      it.l = (i == n - 1);
      word_q.insert(word_q.size(), it);
    end
    n_items += n;
    module_q.delete();
  endfunction

  function automatic void add_random_module();
    int n_inst;
    int r;
    put_header();
    n_inst = $urandom_range(0, 4);
    for (int i = 0; i < n_inst; i++) begin
      r = $urandom_range(0, 99);
      if (r < 28) begin
        put_inst(plain_op(), $urandom_range(1, 6));
      end else if (r < 52) begin
        put_inst(r[0] ? OP_DEC_STR : OP_MEMBER_DEC_STR, $urandom_range(1, HOLD));
      end else if (r < 68) begin
        put_ext($urandom_range(NAME_MIN_WORDS, HOLD), 1'b0);
      end else if (r < 76) begin
        put_ext($urandom_range(NAME_MIN_WORDS, HOLD), 1'b1);
      end else if (r < 82) begin
        put_ext($urandom_range(1, NAME_MIN_WORDS - 1), 1'b0);
      end else if (r < 89) begin
        put_inst(cand_op(), $urandom_range(HOLD + 1, HOLD + 6));
      end else if (r < 96) begin
        // zero word count: the rest of the module goes through untouched
        put_inst(($urandom & 1) ? cand_op() : plain_op(), 0);
        for (int k = $urandom_range(0, 3); k > 0; k--) add_mod($urandom);
        break;
      end else begin
        // maximal word count, cut short by the end of the module
        put_inst(($urandom & 1) ? cand_op() : plain_op(), 16'hFFFF);
        break;
      end
    end
    close_module(($urandom_range(0, 4) == 0) ? $urandom_range(1, module_q.size()) : 0);
  endfunction

  // ---------------------------------------------------------------- sender
  src_item_t cur_item;
  logic      in_taken = 1'b0;
  int        in_gap = 0;
  bit        in_calm = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        cur_item = word_q.pop_front();
        word <= cur_item.w;
        last <= cur_item.l;
        in_valid <= 1'b1;
        if (($urandom & 15) == 0) in_calm = ~in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      clear_strip();
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        strip_word(word, last);
        n_words_in <= n_words_in + 1;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  logic out_taken = 1'b0;
  int   out_wait = 0;
  int   out_gap;
  bit   out_calm = 1'b0;
  bit   squeeze_done = 1'b0;
  int   squeeze_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_wait <= 0;
    end else if (!squeeze_done && n_words_in >= SQUEEZE_AT) begin
      // long hold-off so the block backs up into its input
      squeeze_done <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
      out_stall <= 1'b1;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
      out_stall <= 1'b1;
    end else if (out_taken) begin
      if (($urandom & 15) == 0) out_calm = ~out_calm;
      out_gap = out_calm ? 0 : $urandom_range(0, 7);
      out_stall <= (out_gap != 0);
      out_wait <= (out_gap != 0) ? out_gap - 1 : 0;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      n_err++;
    end
  endtask

  kept_t exp_r;

  always @(posedge clk) begin
    if (rst) begin
      out_taken <= 1'b0;
    end else begin
      out_taken <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (kept_q.size() == 0) begin
          $error("unexpected item: word_out %h word_valid %b stream_end %b",
                 word_out, word_valid, stream_end);
          n_err++;
        end else begin
          exp_r = kept_q.pop_front();
          check_field("word_out", exp_r.w, word_out);
          check_field("word_valid", exp_r.wv, word_valid);
          check_field("stream_end", exp_r.se, stream_end);
          check_field("hold_overflow", exp_r.ovf, hold_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  int n_directed;

  initial begin
    // header extremes, both decoration kinds, a matching extension, and a module
    // that ends on a dropped instruction
    add_mod(32'hFFFFFFFF);
    add_mod(32'h00000000);
    for (int i = 2; i < HEADER_WORDS; i++) add_mod($urandom);
    put_inst(OP_DEC_STR, 1);
    put_ext(NAME_MIN_WORDS, 1'b0);
    put_inst(16'hFFFF, 1);
    put_inst(OP_MEMBER_DEC_STR, 2);
    close_module(0);
    // short module
    add_mod(32'hFFFFFFFF);
    close_module(0);
    // module ends while an extension is held
    put_header();
    put_ext(3, 1'b0);
    close_module(HEADER_WORDS + 2);
    // oversized candidate cut short
    put_header();
    put_inst(OP_EXTENSION, 16'hFFFF);
    close_module(HEADER_WORDS + 2);
    n_directed = n_items;
    while (n_items < n_directed + RANDOM_ITEMS) add_random_module();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (n_words_in != n_items) @(posedge clk);
    while (kept_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
